// ----- design/sentinel_slot_table_defines.svh -----
// Assertion macros shared by the slot table checker.
`ifndef SENTINEL_SLOT_TABLE_DEFINES_SVH
`define SENTINEL_SLOT_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define SST_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sst_pkg.sv -----
// Shared types, codes and microcode table of the slot table.
package sst_pkg;

   localparam int SLOTS_DEFAULT = 16;

   // operation codes
   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_DEL_IDX = 2'd1;
   localparam logic [1:0] OP_DEL_VAL = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_MISSING = 2'd2;
   localparam logic [1:0] STAT_RANGE   = 2'd3;

   // register indexes
   localparam logic REG_MARKER = 1'b0;
   localparam logic REG_IN_USE = 1'b1;

   // sequencer steps
   localparam int         STEP_W     = 2;
   localparam logic [1:0] STEP_IDLE  = 2'd0;
   localparam logic [1:0] STEP_SCAN  = 2'd1;
   localparam logic [1:0] STEP_DRAIN = 2'd2;
   localparam logic [1:0] STEP_WRITE = 2'd3;

   // jump conditions
   localparam logic [1:0] JC_ALWAYS   = 2'd0;
   localparam logic [1:0] JC_REQ      = 2'd1;
   localparam logic [1:0] JC_LAST     = 2'd2;
   localparam logic [1:0] JC_OUT_FREE = 2'd3;

   typedef struct packed {
      logic              req_ready;
      logic              issue;
      logic              commit;
      logic [1:0]        jump_cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // datapath controls driven by the sequencer
   typedef struct packed {
      logic req_ready;
      logic issue;
      logic commit;
   } ctrl_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic scan_last;
      logic out_free;
   } cond_type;

   // Control store: jump to target when the condition holds, else hold the step
   function automatic ucode_type sst_ucode(input logic [STEP_W-1:0] step);
      ucode_type uw;
      uw = '0;
      case (step)
         STEP_IDLE: begin
            uw.req_ready = 1'b1;
            uw.jump_cond = JC_REQ;
            uw.target    = STEP_SCAN;
         end
         STEP_SCAN: begin
            uw.issue     = 1'b1;
            uw.jump_cond = JC_LAST;
            uw.target    = STEP_DRAIN;
         end
         STEP_DRAIN: begin
            uw.jump_cond = JC_ALWAYS;
            uw.target    = STEP_WRITE;
         end
         STEP_WRITE: begin
            uw.commit    = 1'b1;
            uw.jump_cond = JC_OUT_FREE;
            uw.target    = STEP_IDLE;
         end
         default: begin
            uw.jump_cond = JC_ALWAYS;
            uw.target    = STEP_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

// ----- design/sentinel_slot_table.sv -----
// Slot table top level: handshakes, config registers and scan datapath.
// Usage: a request on req_ (operation in tuser; slot index and value in tdata)
// adds a value to the lowest empty slot, deletes at an index, deletes the
// lowest slot holding a value, or queries a slot. Each request yields one
// response on rsp_ with the removed value, a status code and the table
// summary (occupied count, sum, empty/full/holds-one flags, slot bit test).
// Each request walks the single read port of the slot RAM once, one slot a
// cycle, over the n active slots (at most 16 with the default build), then
// passes a drain step and a commit step.
// One request is in flight at a time; req_tready is high only while idle.
// The response sits in an output register, so a stalled receiver holds it
// while the next request is scanned; the commit waits until the register
// frees. Reset empties every slot (valid bits cleared), sets the marker to 0
// and the active count to 16. A write to either CSR empties the table at once;
// the user must write CSRs only while no request is outstanding (not enforced).
module sentinel_slot_table #(
   parameter int SLOTS = sst_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // operation
   input  logic [39:0] req_tdata,   // slot_index[3:0], item_value[35:4], zero pad
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // removed_value, status, occupied, total,
                                    // is_empty, is_full, has_one, slot_is_bit, pad
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PTR_W  = (ADDR_W > 5) ? ADDR_W : 5;
   localparam logic [4:0] SLOTS_CAP = (SLOTS < 31) ? 5'(SLOTS) : 5'd31;

   sst_pkg::ctrl_type ctrl;
   sst_pkg::cond_type cond;

   // configuration registers
   logic signed [31:0] marker_ff;
   logic [4:0]         in_use_ff;
   logic               csr_wr;

   // captured request
   logic [1:0]         op_ff;
   logic [3:0]         idx_ff;
   logic signed [31:0] val_ff;
   logic [4:0]         n_ff, n_in;

   // scan state
   logic [PTR_W-1:0]   ptr_ff, i_pend_ff;
   logic               pend_ff, valid_rd_ff;
   logic [SLOTS-1:0]   valid_ff;
   logic               found_ff;
   logic [ADDR_W-1:0]  hit_ff;
   logic signed [31:0] removed_ff;
   logic               bit_ff, one_ff;
   logic [4:0]         cnt_ff;
   logic [35:0]        sum_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] o_removed_ff;
   logic [1:0]         o_status_ff;
   logic [4:0]         o_cnt_ff;
   logic [35:0]        o_sum_ff;
   logic               o_empty_ff, o_full_ff, o_one_ff, o_bit_ff;

   logic               accept;
   logic [31:0]        rd_data;
   logic signed [31:0] v, eff;
   logic               hit_now, is_idx, idx_ok;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        wr_data;
   logic [1:0]         status;

   sst_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   sst_ram #(.WIDTH(32), .DEPTH(SLOTS), .ADDR_W(ADDR_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.issue),
      .rd_addr (ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // handshakes and sequencer conditions
   assign req_tready     = ctrl.req_ready;
   assign accept         = req_tvalid & ctrl.req_ready;
   assign cond.req_valid = req_tvalid;
   assign cond.scan_last = (ptr_ff == PTR_W'(n_ff - 5'd1));
   assign cond.out_free  = ~rsp_valid_ff | rsp_tready;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == sst_pkg::REG_IN_USE) ? {27'd0, in_use_ff} : marker_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= '0;
         in_use_ff <= 5'd16;
      end else if (csr_wr) begin
         if (csr_paddr[2] == sst_pkg::REG_MARKER) begin
            marker_ff <= csr_pwdata;
         end else begin
            in_use_ff <= csr_pwdata[4:0];
         end
      end
   end

   // active slot count: zero acts as one, capped at the built size
   always_comb begin
      if (in_use_ff == 5'd0) begin
         n_in = 5'd1;
      end else if (in_use_ff > SLOTS_CAP) begin
         n_in = SLOTS_CAP;
      end else begin
         n_in = in_use_ff;
      end
   end

   // per-slot evaluation of the word coming back from the RAM
   always_comb begin
      v       = valid_rd_ff ? rd_data : marker_ff;
      is_idx  = (i_pend_ff == PTR_W'(idx_ff));
      hit_now = 1'b0;
      if (op_ff == sst_pkg::OP_ADD) begin
         hit_now = ~found_ff & (v == marker_ff);
      end else if (op_ff == sst_pkg::OP_DEL_VAL) begin
         hit_now = ~found_ff & (v == val_ff);
      end
      eff = v;
      if (op_ff == sst_pkg::OP_ADD && hit_now) begin
         eff = val_ff;
      end else if (op_ff == sst_pkg::OP_DEL_VAL && hit_now) begin
         eff = marker_ff;
      end else if (op_ff == sst_pkg::OP_DEL_IDX && is_idx) begin
         eff = marker_ff;
      end
   end

   // scan pointer, read pipeline and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctrl.issue;
      end
      if (accept) begin
         op_ff      <= req_tuser;
         idx_ff     <= req_tdata[3:0];
         val_ff     <= req_tdata[35:4];
         n_ff       <= n_in;
         ptr_ff     <= '0;
         found_ff   <= 1'b0;
         removed_ff <= '0;
         bit_ff     <= 1'b0;
         one_ff     <= 1'b0;
         cnt_ff     <= '0;
         sum_ff     <= '0;
      end else begin
         if (ctrl.issue) begin
            ptr_ff      <= ptr_ff + PTR_W'(1);
            i_pend_ff   <= ptr_ff;
            valid_rd_ff <= valid_ff[ptr_ff[ADDR_W-1:0]];
         end
         if (pend_ff) begin
            if (hit_now) begin
               found_ff <= 1'b1;
               hit_ff   <= i_pend_ff[ADDR_W-1:0];
            end
            if (op_ff == sst_pkg::OP_DEL_IDX && is_idx) begin
               removed_ff <= v;
            end
            if (op_ff == sst_pkg::OP_QUERY && is_idx) begin
               bit_ff <= (v == 32'sd0) || (v == 32'sd1);
            end
            if (eff != marker_ff) begin
               cnt_ff <= cnt_ff + 5'd1;
               sum_ff <= sum_ff + {{4{eff[31]}}, eff};
            end
            if (eff == 32'sd1) begin
               one_ff <= 1'b1;
            end
         end
      end
   end

   // commit: slot update and status
   assign idx_ok = ({1'b0, idx_ff} < n_ff);

   always_comb begin
      case (op_ff)
         sst_pkg::OP_ADD:     status = found_ff ? sst_pkg::STAT_OK : sst_pkg::STAT_FULL;
         sst_pkg::OP_DEL_VAL: status = found_ff ? sst_pkg::STAT_OK : sst_pkg::STAT_MISSING;
         sst_pkg::OP_DEL_IDX: status = idx_ok ? sst_pkg::STAT_OK : sst_pkg::STAT_RANGE;
         sst_pkg::OP_QUERY:   status = idx_ok ? sst_pkg::STAT_OK : sst_pkg::STAT_RANGE;
         default:             status = sst_pkg::STAT_OK;
      endcase
   end

   assign wr_en   = ctrl.commit &
                    ((op_ff == sst_pkg::OP_DEL_IDX) ? idx_ok :
                     ((op_ff == sst_pkg::OP_ADD || op_ff == sst_pkg::OP_DEL_VAL) & found_ff));
   assign wr_addr = (op_ff == sst_pkg::OP_DEL_IDX) ? ADDR_W'(idx_ff) : hit_ff;
   assign wr_data = (op_ff == sst_pkg::OP_ADD) ? val_ff : marker_ff;

   // slot valid bits: a slot never written reads as the marker
   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.commit) begin
         o_removed_ff <= removed_ff;
         o_status_ff  <= status;
         o_cnt_ff     <= cnt_ff;
         o_sum_ff     <= sum_ff;
         o_empty_ff   <= (cnt_ff == 5'd0);
         o_full_ff    <= (cnt_ff == n_ff);
         o_one_ff     <= one_ff;
         o_bit_ff     <= bit_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, o_bit_ff, o_one_ff, o_full_ff, o_empty_ff,
                        o_sum_ff, o_cnt_ff, o_status_ff, o_removed_ff};

endmodule

// ----- design/sst_ram.sv -----
// Generic single-port-write, registered-read RAM.
module sst_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sst_seq.sv -----
// Microcoded sequencer: step counter, control store and conditional jumps.
module sst_seq (
   input  logic              clock,
   input  logic              reset,
   input  sst_pkg::cond_type cond,
   output sst_pkg::ctrl_type ctrl
);

   logic [sst_pkg::STEP_W-1:0] step_ff, step_in;
   sst_pkg::ucode_type         uw;
   logic                       jump_ok;

   assign uw = sst_pkg::sst_ucode(step_ff);

   // jump condition select
   always_comb begin
      case (uw.jump_cond)
         sst_pkg::JC_ALWAYS:   jump_ok = 1'b1;
         sst_pkg::JC_REQ:      jump_ok = cond.req_valid;
         sst_pkg::JC_LAST:     jump_ok = cond.scan_last;
         sst_pkg::JC_OUT_FREE: jump_ok = cond.out_free;
         default:              jump_ok = 1'b1;
      endcase
      step_in = jump_ok ? uw.target : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= sst_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.req_ready = uw.req_ready;
   assign ctrl.issue     = uw.issue;
   assign ctrl.commit    = uw.commit & cond.out_free;

endmodule

// ----- design/sst_checker.sv -----
// Port-level checker for the slot table, bound to the top level.
`include "sentinel_slot_table_defines.svh"

module sst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // a stalled response holds its payload
   `SST_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // empty flag agrees with the occupied count
   `SST_ASSERT_ALWAYS(a_empty_cnt, !rsp_tvalid || (rsp_tdata[75] == (rsp_tdata[38:34] == 5'd0)), "empty flag disagrees with count")

   // out-of-range requests report no removed value and no bit
   `SST_ASSERT_ALWAYS(a_range_zero, !rsp_tvalid || rsp_tdata[33:32] != sst_pkg::STAT_RANGE || (rsp_tdata[31:0] == 32'd0 && !rsp_tdata[78]), "range error with payload")

   // a full status comes only with the full flag set
   `SST_ASSERT_ALWAYS(a_full_flag, !rsp_tvalid || rsp_tdata[33:32] != sst_pkg::STAT_FULL || rsp_tdata[76], "full status without full flag")

endmodule

bind sentinel_slot_table sst_checker u_sst_checker (.*);

// ----- tb/sv/sentinel_slot_table_tb.sv -----
// Self-checking testbench of the first-free slot table.
module sentinel_slot_table_tb;

   localparam int TABLE_SLOTS = sst_pkg::SLOTS_DEFAULT;
   localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction before giving up
   localparam int LONG_HOLD   = 300;   // receiver hold-off for the backpressure test
   localparam int SETTLE      = 24;    // settling time after the last response before a register write
   localparam int PHASE_ITEMS = 295;

   // receiver stall patterns
   localparam int SINK_OPEN   = 0;
   localparam int SINK_MOSTLY = 1;
   localparam int SINK_SPARSE = 2;

   // one response, packed exactly as rsp_tdata[78:0]
   typedef struct packed {
      logic        slot_is_bit;
      logic        has_one;
      logic        is_full;
      logic        is_empty;
      logic [35:0] total;
      logic [4:0]  occupied;
      logic [1:0]  status;
      logic [31:0] removed_value;
   } table_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // operation
   logic [39:0] req_tdata;   // slot_index[3:0], item_value[35:4], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // removed_value, status, occupied, total,
                             // is_empty, is_full, has_one, slot_is_bit, pad
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the table and its registers
   logic [31:0]      slot_store [TABLE_SLOTS];
   logic [31:0]      empty_marker;
   int unsigned      active_count;
   table_result_type pending_results [$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles;
   int unsigned burst_left;
   int unsigned hold_requests = 0;  // bumped by the test to ask for a long hold-off

   sentinel_slot_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow table and return the response it yields
   function automatic table_result_type predict_table_op(input logic [1:0] op,
                                                         input logic [3:0] idx,
                                                         input logic [31:0] val);
      table_result_type r;
      int unsigned      hit;
      logic [31:0]      want;
      r = '0;
      if (op == sst_pkg::OP_ADD || op == sst_pkg::OP_DEL_VAL) begin
         // lowest empty slot for add, lowest matching slot for delete
         want = (op == sst_pkg::OP_ADD) ? empty_marker : val;
         hit  = active_count;
         for (int i = 0; i < active_count; i++) begin
            if (hit == active_count && slot_store[i] == want) hit = i;
         end
         if (hit < active_count) begin
            slot_store[hit] = (op == sst_pkg::OP_ADD) ? val : empty_marker;
         end else begin
            r.status = (op == sst_pkg::OP_ADD) ? sst_pkg::STAT_FULL : sst_pkg::STAT_MISSING;
         end
      end else if (idx >= active_count) begin
         r.status = sst_pkg::STAT_RANGE;
      end else if (op == sst_pkg::OP_DEL_IDX) begin
         r.removed_value = slot_store[idx];
         slot_store[idx] = empty_marker;
      end else begin
         r.slot_is_bit = (slot_store[idx] == 32'd0 || slot_store[idx] == 32'd1);
      end
      // summary over the active slots; one-test looks at raw contents
      for (int i = 0; i < active_count; i++) begin
         if (slot_store[i] != empty_marker) begin
            r.occupied = r.occupied + 5'd1;
            r.total    = r.total + {{4{slot_store[i][31]}}, slot_store[i]};
         end
         if (slot_store[i] == 32'd1) r.has_one = 1'b1;
      end
      r.is_empty = (r.occupied == 5'd0);
      r.is_full  = (r.occupied == active_count);
      return r;
   endfunction

   // Value mix: marker, bit values, extremes, current contents, small values and raw random
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return empty_marker;
         1: return 32'd0;
         2: return 32'd1;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return 32'hFFFF_FFFF;
         6, 7: return slot_store[$urandom_range(0, active_count - 1)];
         8: return 32'($urandom_range(0, 8)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request in bursts with random gaps; predict once it is taken
   task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                               input logic [31:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, val, idx};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_table_op(op, idx, val));
   endtask

   // Drain every response and let the block settle before a register write
   task automatic wait_table_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Both writes clear the table to the current marker
   task automatic configure_table(input logic [31:0] marker, input logic [4:0] in_use);
      wait_table_idle();
      write_csr({sst_pkg::REG_MARKER, 2'b00}, marker);
      write_csr({sst_pkg::REG_IN_USE, 2'b00}, {27'd0, in_use});
      empty_marker = marker;
      if (in_use == 5'd0) active_count = 1;
      else if (in_use > TABLE_SLOTS) active_count = TABLE_SLOTS;
      else active_count = in_use;
      for (int i = 0; i < TABLE_SLOTS; i++) slot_store[i] = marker;
   endtask

   // Reset state: marker zero, so empty slots pass the bit test
   task automatic test_basic_ops();
      send_request(sst_pkg::OP_QUERY, 4'd0, 32'd0);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'd1);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'h7FFF_FFFF);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'h8000_0000);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'd0);            // the marker itself stays empty
      send_request(sst_pkg::OP_QUERY, 4'd0, 32'd0);
      send_request(sst_pkg::OP_QUERY, 4'd15, 32'hFFFF_FFFF);
      send_request(sst_pkg::OP_DEL_IDX, 4'd0, 32'd0);
      send_request(sst_pkg::OP_DEL_IDX, 4'd9, 32'd0);        // empty slot gives back the marker
      send_request(sst_pkg::OP_DEL_VAL, 4'd0, 32'h8000_0000);
      send_request(sst_pkg::OP_DEL_VAL, 4'd0, 32'h1234_5678); // not present
   endtask

   // Two active slots with marker one: full table, out-of-range index, one-tests
   task automatic test_small_table();
      configure_table(32'd1, 5'd2);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'd7);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'hFFFF_FFF9);
      send_request(sst_pkg::OP_ADD, 4'd0, 32'd9);
      send_request(sst_pkg::OP_DEL_IDX, 4'd15, 32'd0);
      send_request(sst_pkg::OP_QUERY, 4'd2, 32'd0);
      send_request(sst_pkg::OP_QUERY, 4'd0, 32'd0);
      send_request(sst_pkg::OP_DEL_VAL, 4'd0, 32'd7);
      send_request(sst_pkg::OP_QUERY, 4'd0, 32'd0);
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      configure_table(32'd0, 5'd4);
      hold_requests++;
      for (int k = 0; k < 16; k++) begin
         send_request((k % 3 == 0) ? sst_pkg::OP_QUERY : sst_pkg::OP_ADD,
                      4'($urandom_range(0, 7)), pick_value());
      end
   endtask

   // Random traffic alternating fill-heavy and drain-heavy stretches
   task automatic test_random_phase(input logic [31:0] marker, input logic [4:0] in_use);
      int unsigned add_bias;
      int unsigned roll;
      logic [1:0]  op;
      logic [3:0]  idx;
      configure_table(marker, in_use);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         add_bias = ((k / 40) % 2 == 0) ? 60 : 20;
         roll     = $urandom_range(0, 99);
         if (roll < add_bias) op = sst_pkg::OP_ADD;
         else if (roll < add_bias + (100 - add_bias) / 3) op = sst_pkg::OP_DEL_IDX;
         else if (roll < add_bias + 2 * (100 - add_bias) / 3) op = sst_pkg::OP_DEL_VAL;
         else op = sst_pkg::OP_QUERY;
         if ($urandom_range(0, 4) == 0) idx = 4'($urandom_range(0, 15));
         else idx = 4'($urandom_range(0, active_count - 1));
         send_request(op, idx, pick_value());
      end
   endtask

   // Compare each response with the oldest prediction
   always @(posedge clock) begin : response_check
      table_result_type got;
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = table_result_type'(rsp_tdata[78:0]);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch (removed status occupied total empty full one bit)");
                  $display("  expected %h %0d %0d %h %b %b %b %b", want.removed_value,
                           want.status, want.occupied, want.total, want.is_empty,
                           want.is_full, want.has_one, want.slot_is_bit);
                  $display("  actual   %h %0d %0d %h %b %b %b %b", got.removed_value,
                           got.status, got.occupied, got.total, got.is_empty,
                           got.is_full, got.has_one, got.slot_is_bit);
               end
            end
         end
      end
   end

   // Receiver: random stall patterns, plus a long hold-off on request
   initial begin
      int unsigned sink_mode;
      int unsigned sink_left;
      int unsigned holds_done;
      sink_mode  = SINK_OPEN;
      sink_left  = 0;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_tready <= 1'b0;
            for (int h = 0; h < LONG_HOLD; h++) @(posedge clock);
         end else begin
            if (sink_left == 0) begin
               sink_mode = $urandom_range(SINK_OPEN, SINK_SPARSE);
               sink_left = $urandom_range(16, 200);
            end
            sink_left--;
            case (sink_mode)
               SINK_OPEN:   rsp_tready <= 1'b1;
               SINK_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:     rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tuser      = '0;
      req_tdata      = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      burst_left     = 0;
      empty_marker   = 32'd0;
      active_count   = TABLE_SLOTS;
      for (int i = 0; i < TABLE_SLOTS; i++) slot_store[i] = 32'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_small_table();
      test_backpressure();
      test_random_phase(32'd0, 5'd16);
      test_random_phase(32'h8000_0000, 5'd1);
      test_random_phase(32'h7FFF_FFFF, 5'd16);
      test_random_phase(32'd1, 5'd3);
      test_random_phase($urandom, 5'($urandom_range(1, 16)));
      test_random_phase(32'hFFFF_FFFF, 5'd8);

      wait_table_idle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/sst_pkg.sv
design/sst_ram.sv
design/sst_seq.sv
design/sentinel_slot_table.sv
design/sst_checker.sv
tb/sv/sentinel_slot_table_tb.sv
